// ----- sv/acm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acm_pkg
// Shared types, the AES S-box and the round and subkey helper functions.
// ----------------------------------------------------------------------------
package acm_pkg;

  localparam int BLOCK_BYTES = 16;
  localparam logic [7:0] CMAC_RB  = 8'h87;
  localparam logic [7:0] PAD_BYTE = 8'h80;

  // Operation codes carried on the input tuser bit.
  localparam logic OP_ABSORB = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  // Configuration register indexes.
  localparam logic [2:0] REG_KEY_WORD_0 = 3'd0;
  localparam logic [2:0] REG_KEY_WORD_1 = 3'd1;
  localparam logic [2:0] REG_KEY_WORD_2 = 3'd2;
  localparam logic [2:0] REG_KEY_WORD_3 = 3'd3;
  localparam logic [2:0] REG_KEY_SIZE   = 3'd4;

  // Key size codes.
  localparam logic [1:0] KEY_128 = 2'd0;
  localparam logic [1:0] KEY_192 = 2'd1;

  // One queued input transaction.
  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } item_t;

  // Requests from the CMAC controller to the AES unit.
  typedef struct packed {
    logic kexp;
    logic enc;
  } aes_req_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // Multiply by x in GF(2^8).
  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // S-box applied to each byte of a word.
  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // One AES round without the key addition; byte 0 sits in the top bits.
  function automatic logic [127:0] aes_round(input logic [127:0] st, input logic last);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3;
    logic [127:0] r;
    for (int i = 0; i < 16; i++) s[i] = SBOX[st[127-8*i -: 8]];
    for (int c = 0; c < 4; c++)
      for (int j = 0; j < 4; j++) t[c*4+j] = s[((c+j) & 3)*4+j];
    for (int c = 0; c < 4; c++) begin
      a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
      if (last) begin
        r[127-32*c -: 32] = {a0, a1, a2, a3};
      end else begin
        r[127-32*c -: 8]      = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
        r[127-32*c-8 -: 8]    = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
        r[127-32*c-16 -: 8]   = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
        r[127-32*c-24 -: 8]   = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
      end
    end
    return r;
  endfunction

  // Doubling in GF(2^128) as used for CMAC subkeys.
  function automatic logic [127:0] gf_double(input logic [127:0] x);
    return {x[126:0], 1'b0} ^ {120'd0, (x[127] ? CMAC_RB : 8'h00)};
  endfunction

endpackage

// ----- sv/acm_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acm_front
// Input side: takes stream transactions and queues them for the controller.
// ----------------------------------------------------------------------------
module acm_front import acm_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_op,
  input  logic [7:0] in_byte,
  output logic       q_valid,
  output item_t      q_item,
  input  logic       q_pop
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  item_t           mem [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [PW:0]     count;
  logic            push;

  assign in_ready = (count < (PW+1)'(DEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != '0);
  assign q_item   = mem[rd_ptr];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= '{op: in_op, data_byte: in_byte};
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (PW+1)'(push) - (PW+1)'(q_pop);
    end
  end

endmodule

// ----- sv/acm_aes.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acm_aes
// Iterative AES encryptor: key schedule one word a cycle, one round a cycle.
// ----------------------------------------------------------------------------
module acm_aes import acm_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic [255:0]   key_all,
  input  logic [1:0]     key_size,
  input  aes_req_t       req,
  input  logic [127:0]   blk,
  output logic           done,
  output logic [127:0]   result
);

  typedef enum logic [1:0] {A_IDLE, A_KEXP, A_RUN} astate_t;

  astate_t      state;
  logic [3:0]   nk;
  logic [3:0]   nr;
  logic [5:0]   total;
  logic [5:0]   kidx;
  logic [2:0]   kmod;
  logic [7:0]   rcon;
  logic [31:0]  win [8];
  logic [31:0]  back_word;
  logic [31:0]  tmp;
  logic [31:0]  new_word;
  logic [127:0] st;
  logic [3:0]   rnd;
  logic [3:0]   rd_addr;
  logic [31:0]  bank [4][16];
  logic [127:0] rk_q;

  assign result = st;

  // Key length figures.
  always_comb begin
    case (key_size)
      KEY_128: begin nk = 4'd4; nr = 4'd10; total = 6'd44; end
      KEY_192: begin nk = 4'd6; nr = 4'd12; total = 6'd52; end
      default: begin nk = 4'd8; nr = 4'd14; total = 6'd60; end
    endcase
  end

  // Word that lies nk places back in the schedule.
  always_comb begin
    case (key_size)
      KEY_128: back_word = win[3];
      KEY_192: back_word = win[5];
      default: back_word = win[7];
    endcase
  end

  // Next schedule word.
  always_comb begin
    tmp = win[0];
    if (kmod == 3'd0) begin
      tmp = sub_word({win[0][23:0], win[0][31:24]}) ^ {rcon, 24'd0};
    end else if (nk == 4'd8 && kmod == 3'd4) begin
      tmp = sub_word(win[0]);
    end
    if (kidx < {2'b00, nk}) begin
      new_word = key_all[(7 - int'(kidx[2:0]))*32 +: 32];
    end else begin
      new_word = back_word ^ tmp;
    end
  end

  assign rd_addr = (state == A_RUN) ? rnd + 4'd1 : 4'd0;

  // Round key store, one bank per word of a round key.
  always_ff @(posedge clk) begin
    if (state == A_KEXP) begin
      bank[kidx[1:0]][kidx[5:2]] <= new_word;
    end
    rk_q <= {bank[0][rd_addr], bank[1][rd_addr], bank[2][rd_addr], bank[3][rd_addr]};
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= A_IDLE;
      done  <= 1'b0;
      kidx  <= '0;
      kmod  <= '0;
      rcon  <= 8'h01;
      rnd   <= '0;
    end else begin
      case (state)
        A_IDLE: begin
          done <= 1'b0;
          if (req.kexp) begin
            kidx  <= '0;
            kmod  <= '0;
            rcon  <= 8'h01;
            state <= A_KEXP;
          end else if (req.enc) begin
            st    <= blk;
            rnd   <= '0;
            state <= A_RUN;
          end
        end
        A_KEXP: begin
          win[0] <= new_word;
          for (int k = 1; k < 8; k++) win[k] <= win[k-1];
          if (kidx >= {2'b00, nk} && kmod == 3'd0) rcon <= xtime(rcon);
          kmod <= (kmod == 3'(nk - 4'd1)) ? 3'd0 : kmod + 3'd1;
          kidx <= kidx + 6'd1;
          done <= (kidx == total - 6'd1);
          if (kidx == total - 6'd1) begin
            state <= A_IDLE;
          end
        end
        A_RUN: begin
          if (rnd == 4'd0) st <= st ^ rk_q;
          else             st <= aes_round(st, rnd == nr) ^ rk_q;
          rnd  <= rnd + 4'd1;
          done <= (rnd == nr);
          if (rnd == nr) begin
            state <= A_IDLE;
          end
        end
        default: begin
          done  <= 1'b0;
          state <= A_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- sv/acm_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acm_back
// CMAC controller: subkeys, block gathering, chaining, padding and the tag.
// ----------------------------------------------------------------------------
module acm_back import acm_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_hit,
  input  logic           q_valid,
  input  item_t          q_item,
  output logic           q_pop,
  output aes_req_t       aes_req,
  output logic [127:0]   aes_blk,
  input  logic           aes_done,
  input  logic [127:0]   aes_res,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [127:0]   out_tag
);

  typedef enum logic [2:0] {B_IDLE, B_KEXP, B_LWAIT, B_CHAIN, B_FIN, B_OUT} bstate_t;

  bstate_t      state;
  logic [127:0] chain;
  logic [127:0] pend;
  logic [4:0]   cnt;
  logic         seen;
  logic         ready;
  logic [127:0] k1;
  logic [127:0] k2;
  logic [7:0]   hold;
  logic [127:0] tag;
  logic [127:0] last_blk;

  assign q_pop = (state == B_IDLE) && ready && q_valid;

  // Final block: full block with K1, otherwise padded with K2.
  always_comb begin
    if (seen && cnt == 5'd16) begin
      last_blk = pend ^ k1;
    end else begin
      for (int i = 0; i < BLOCK_BYTES; i++) begin
        if (5'(i) < cnt)       last_blk[127-8*i -: 8] = pend[127-8*i -: 8];
        else if (5'(i) == cnt) last_blk[127-8*i -: 8] = PAD_BYTE;
        else                   last_blk[127-8*i -: 8] = 8'h00;
      end
      last_blk = last_blk ^ k2;
    end
  end

  // Message byte store.
  always_ff @(posedge clk) begin
    if (q_pop && q_item.op == OP_ABSORB && cnt != 5'd16) begin
      pend[(15 - int'(cnt[3:0]))*8 +: 8] <= q_item.data_byte;
    end else if (state == B_CHAIN && aes_done) begin
      pend[127:120] <= hold;
    end
  end

  // Controller.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      chain     <= '0;
      cnt       <= '0;
      seen      <= 1'b0;
      ready     <= 1'b0;
      aes_req   <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        B_IDLE: begin
          if (q_valid && !ready) begin
            aes_req <= '{kexp: 1'b1, enc: 1'b0};
            state   <= B_KEXP;
          end else if (q_pop) begin
            if (q_item.op == OP_FINISH) begin
              aes_req <= '{kexp: 1'b0, enc: 1'b1};
              aes_blk <= chain ^ last_blk;
              state   <= B_FIN;
            end else if (cnt == 5'd16) begin
              aes_req <= '{kexp: 1'b0, enc: 1'b1};
              aes_blk <= chain ^ pend;
              hold    <= q_item.data_byte;
              state   <= B_CHAIN;
            end else begin
              aes_req <= '0;
              cnt     <= cnt + 5'd1;
              seen    <= 1'b1;
            end
          end else begin
            aes_req <= '0;
          end
        end
        B_KEXP: begin
          if (aes_done) begin
            aes_req <= '{kexp: 1'b0, enc: 1'b1};
            aes_blk <= '0;
            state   <= B_LWAIT;
          end else begin
            aes_req <= '0;
          end
        end
        B_LWAIT: begin
          aes_req <= '0;
          if (aes_done) begin
            k1    <= gf_double(aes_res);
            k2    <= gf_double(gf_double(aes_res));
            ready <= !cfg_hit;
            state <= B_IDLE;
          end
        end
        B_CHAIN: begin
          aes_req <= '0;
          if (aes_done) begin
            chain <= aes_res;
            cnt   <= 5'd1;
            seen  <= 1'b1;
            state <= B_IDLE;
          end
        end
        B_FIN: begin
          aes_req <= '0;
          if (aes_done) begin
            tag   <= aes_res;
            state <= B_OUT;
          end
        end
        B_OUT: begin
          aes_req <= '0;
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_tag   <= tag;
            chain     <= '0;
            cnt       <= '0;
            seen      <= 1'b0;
            state     <= B_IDLE;
          end
        end
        default: begin
          aes_req <= '0;
          state   <= B_IDLE;
        end
      endcase
      // The output register empties once its transaction is taken.
      if (out_valid && out_ready && state != B_OUT) out_valid <= 1'b0;
      // Any register write forces new subkeys before the next item.
      if (cfg_hit && !(state == B_LWAIT && aes_done)) ready <= 1'b0;
    end
  end

endmodule

// ----- sv/aes_cmac_tag_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_cmac_tag_engine
// AES-CMAC tag engine over a byte stream with a configurable AES key.
// ----------------------------------------------------------------------------
// Usage: write the key words and key size through the cfg port while idle.
// Each input transaction carries one message byte (tuser = 0) or a finish
// request (tuser = 1). A finish produces one output transaction holding the
// 128-bit tag; absorb transactions produce none.
// Input transactions enter a short queue; the controller drains it at one
// byte per cycle while idle. A byte that follows a full 16-byte block holds
// the controller while the one-round-per-cycle AES unit encrypts the block.
// The first item after reset or a key write also runs the key schedule (one
// word a cycle) and a subkey encryption before it is handled.
// Reset clears the chaining value, the byte count and the subkey ready flag.
// When the receiver stalls, the tag waits in the output register; input keeps
// being queued until the queue fills, then s_tready drops.
// ----------------------------------------------------------------------------
module aes_cmac_tag_engine import acm_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // data_byte[7:0]
  input  logic         s_tuser,   // op[0]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata,   // tag_high[63:0], tag_low[127:64]
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data
);

  logic [63:0]  key_word_0;
  logic [63:0]  key_word_1;
  logic [63:0]  key_word_2;
  logic [63:0]  key_word_3;
  logic [1:0]   key_size;
  logic         cfg_hit;
  logic         q_valid;
  item_t        q_item;
  logic         q_pop;
  aes_req_t     aes_req;
  logic [127:0] aes_blk;
  logic         aes_done;
  logic [127:0] aes_res;
  logic [127:0] tag;

  assign cfg_hit = cfg_we && (cfg_index <= REG_KEY_SIZE);
  assign m_tdata = {tag[63:0], tag[127:64]};

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_word_0 <= '0;
      key_word_1 <= '0;
      key_word_2 <= '0;
      key_word_3 <= '0;
      key_size   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY_WORD_0: key_word_0 <= cfg_data;
        REG_KEY_WORD_1: key_word_1 <= cfg_data;
        REG_KEY_WORD_2: key_word_2 <= cfg_data;
        REG_KEY_WORD_3: key_word_3 <= cfg_data;
        REG_KEY_SIZE:   key_size   <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  acm_front #(.DEPTH(QUEUE_DEPTH)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_op    (s_tuser),
    .in_byte  (s_tdata),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  acm_aes u_aes (
    .clk      (clk),
    .rst      (rst),
    .key_all  ({key_word_0, key_word_1, key_word_2, key_word_3}),
    .key_size (key_size),
    .req      (aes_req),
    .blk      (aes_blk),
    .done     (aes_done),
    .result   (aes_res)
  );

  acm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_hit   (cfg_hit),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .aes_req   (aes_req),
    .aes_blk   (aes_blk),
    .aes_done  (aes_done),
    .aes_res   (aes_res),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_tag   (tag)
  );

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the AES-CMAC tag engine.
// ----------------------------------------------------------------------------
// Byte and finish transactions are driven on the input stream while a local
// CMAC predictor computes each expected tag. Tags are compared field by field
// against the oldest prediction. Keys of all three sizes are exercised, with
// random idling on both stream sides and a long output stall.
// ----------------------------------------------------------------------------
module tb_top;
  import acm_pkg::*;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [7:0]   s_tdata;    // data_byte[7:0]
  logic         s_tuser;    // op[0]
  logic         m_tvalid;
  logic         m_tready;
  logic [127:0] m_tdata;    // tag_high[63:0], tag_low[127:64]
  logic         cfg_we;
  logic [2:0]   cfg_index;
  logic [63:0]  cfg_data;

  aes_cmac_tag_engine DUT (.*);

  // Predictor state: key, chaining value, pending block and subkeys.
  logic [63:0]  key_w [4];
  logic [1:0]   key_sz;
  logic [127:0] chain_val;
  logic [7:0]   pend [16];
  int           pend_cnt;
  bit           have_data;
  logic [127:0] sub_k1, sub_k2;
  bit           subkeys_ok;

  logic [127:0] tag_queue [$];
  int           err_count;
  int           send_idle_pct;
  int           recv_stall_pct;
  bit           hold_off;

  // Clock.
  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  function automatic logic [7:0] dbl8(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // AES encryption of one block under the predictor's key.
  function automatic logic [127:0] aes_enc(input logic [127:0] blk);
    logic [7:0] rk [240];
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] tmp [4];
    logic [7:0] f, rc, a0, a1, a2, a3;
    int nk, nr;
    nk = (key_sz == KEY_128) ? 4 : (key_sz == KEY_192) ? 6 : 8;
    nr = nk + 6;
    rc = 8'h01;
    for (int i = 0; i < 4 * nk; i++) rk[i] = key_w[i / 8][63 - 8 * (i % 8) -: 8];
    for (int i = nk; i < 4 * (nr + 1); i++) begin
      for (int j = 0; j < 4; j++) tmp[j] = rk[4 * (i - 1) + j];
      if (i % nk == 0) begin
        f = tmp[0];
        tmp[0] = SBOX[tmp[1]] ^ rc;
        tmp[1] = SBOX[tmp[2]];
        tmp[2] = SBOX[tmp[3]];
        tmp[3] = SBOX[f];
        rc = dbl8(rc);
      end else if (nk > 6 && i % nk == 4) begin
        for (int j = 0; j < 4; j++) tmp[j] = SBOX[tmp[j]];
      end
      for (int j = 0; j < 4; j++) rk[4 * i + j] = rk[4 * (i - nk) + j] ^ tmp[j];
    end
    for (int i = 0; i < 16; i++) s[i] = blk[127 - 8 * i -: 8] ^ rk[i];
    for (int r = 1; r <= nr; r++) begin
      for (int i = 0; i < 16; i++) s[i] = SBOX[s[i]];
      for (int c = 0; c < 4; c++)
        for (int j = 0; j < 4; j++) t[c * 4 + j] = s[((c + j) & 3) * 4 + j];
      for (int c = 0; c < 4; c++) begin
        a0 = t[4 * c]; a1 = t[4 * c + 1]; a2 = t[4 * c + 2]; a3 = t[4 * c + 3];
        if (r != nr) begin
          s[4 * c]     = dbl8(a0) ^ dbl8(a1) ^ a1 ^ a2 ^ a3;
          s[4 * c + 1] = a0 ^ dbl8(a1) ^ dbl8(a2) ^ a2 ^ a3;
          s[4 * c + 2] = a0 ^ a1 ^ dbl8(a2) ^ dbl8(a3) ^ a3;
          s[4 * c + 3] = dbl8(a0) ^ a0 ^ a1 ^ a2 ^ dbl8(a3);
        end else begin
          s[4 * c] = a0; s[4 * c + 1] = a1; s[4 * c + 2] = a2; s[4 * c + 3] = a3;
        end
      end
      for (int i = 0; i < 16; i++) s[i] ^= rk[16 * r + i];
    end
    for (int i = 0; i < 16; i++) blk[127 - 8 * i -: 8] = s[i];
    return blk;
  endfunction

  function automatic logic [127:0] times_x(input logic [127:0] v);
    return {v[126:0], 1'b0} ^ (v[127] ? 128'h87 : 128'h0);
  endfunction

  function automatic logic [127:0] pend_block();
    logic [127:0] b;
    for (int i = 0; i < 16; i++) b[127 - 8 * i -: 8] = pend[i];
    return b;
  endfunction

  // Advances the CMAC predictor by one transaction.
  task automatic predict_tag(input logic op, input logic [7:0] byte_in);
    logic [127:0] last_blk;
    if (!subkeys_ok) begin
      sub_k1 = times_x(aes_enc(128'h0));
      sub_k2 = times_x(sub_k1);
      subkeys_ok = 1'b1;
    end
    if (op == OP_ABSORB) begin
      if (pend_cnt >= 16) begin
        chain_val = aes_enc(chain_val ^ pend_block());
        pend_cnt = 0;
      end
      pend[pend_cnt] = byte_in;
      pend_cnt++;
      have_data = 1'b1;
    end else begin
      if (have_data && pend_cnt >= 16) begin
        last_blk = pend_block() ^ sub_k1;
      end else begin
        last_blk = '0;
        for (int i = 0; i < pend_cnt; i++) last_blk[127 - 8 * i -: 8] = pend[i];
        last_blk[127 - 8 * (pend_cnt % 16) -: 8] = PAD_BYTE;
        last_blk ^= sub_k2;
      end
      chain_val = aes_enc(chain_val ^ last_blk);
      tag_queue.push_back(chain_val);
      chain_val = '0;
      pend_cnt = 0;
      have_data = 1'b0;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("tb_top: %s mismatch got %h expected %h at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  // Sends one transaction and updates the prediction on acceptance.
  task automatic send_item(input logic op, input logic [7:0] byte_in);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    s_tvalid = 1'b1;
    s_tuser  = op;
    s_tdata  = byte_in;
    do @(posedge clk); while (!s_tready);
    predict_tag(op, byte_in);
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) send_item(OP_ABSORB, 8'($urandom));
    send_item(OP_FINISH, 8'($urandom));
  endtask

  // Waits for all tags, then lets the engine settle before a key write.
  task automatic drain();
    while (tag_queue.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_KEY_WORD_0: key_w[0] = val;
      REG_KEY_WORD_1: key_w[1] = val;
      REG_KEY_WORD_2: key_w[2] = val;
      REG_KEY_WORD_3: key_w[3] = val;
      REG_KEY_SIZE:   key_sz = val[1:0];
      default: ;
    endcase
    subkeys_ok = 1'b0;
  endtask

  task automatic load_key(input logic [1:0] sz, input logic [63:0] w0, input logic [63:0] w1,
                          input logic [63:0] w2, input logic [63:0] w3);
    drain();
    write_reg(REG_KEY_WORD_0, w0);
    write_reg(REG_KEY_WORD_1, w1);
    write_reg(REG_KEY_WORD_2, w2);
    write_reg(REG_KEY_WORD_3, w3);
    write_reg(REG_KEY_SIZE, 64'(sz));
  endtask

  // Output side: random stall, long hold-off, and tag comparison.
  always @(negedge clk) begin
    if (rst || hold_off) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (tag_queue.size() == 0) begin
        report_mismatch("unexpected tag_high", m_tdata[63:0], 64'h0);
      end else begin
        if (m_tdata[63:0] !== tag_queue[0][127:64])
          report_mismatch("tag_high", m_tdata[63:0], tag_queue[0][127:64]);
        if (m_tdata[127:64] !== tag_queue[0][63:0])
          report_mismatch("tag_low", m_tdata[127:64], tag_queue[0][63:0]);
        void'(tag_queue.pop_front());
      end
    end
  end

  // Directed: empty message, boundary lengths, byte extremes, 128-bit and 256-bit keys.
  task automatic test_directed();
    load_key(KEY_128, 64'h2b7e151628aed2a6, 64'habf7158809cf4f3c, 64'h0, 64'h0);
    send_item(OP_FINISH, 8'hff);
    for (int i = 0; i < 16; i++) send_item(OP_ABSORB, (i % 2) ? 8'hff : 8'h00);
    send_item(OP_FINISH, 8'h00);
    send_message(17);
    load_key(2'd3, '1, '1, '1, '1);
    send_message(1);
  endtask

  // Random messages of mostly short lengths under changing keys.
  task automatic test_random(input int items);
    int sent;
    int len;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(3) == 0)
        load_key(2'($urandom_range(2)), {$urandom, $urandom}, {$urandom, $urandom},
                 {$urandom, $urandom}, {$urandom, $urandom});
      len = ($urandom_range(9) == 0) ? $urandom_range(80) : $urandom_range(34);
      send_message(len);
      sent += len + 1;
    end
  endtask

  // Output held off long enough for the input queue to fill up.
  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(negedge clk);
        hold_off = 1'b0;
      end
      begin
        for (int i = 0; i < 8; i++) send_message($urandom_range(3));
      end
    join
    drain();
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0; s_tdata = '0; s_tuser = OP_ABSORB;
    cfg_we = 1'b0; cfg_index = REG_KEY_WORD_0; cfg_data = '0;
    hold_off = 1'b0;
    send_idle_pct = 0; recv_stall_pct = 0;
    err_count = 0;
    foreach (key_w[i]) key_w[i] = '0;
    key_sz = KEY_128; chain_val = '0; pend_cnt = 0; have_data = 1'b0; subkeys_ok = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    load_key(KEY_192, {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
             64'h0);
    test_random(500);
    send_idle_pct = 78;
    test_random(450);
    send_idle_pct = 0; recv_stall_pct = 78;
    test_random(450);
    send_idle_pct = 31; recv_stall_pct = 31;
    test_random(450);
    send_idle_pct = 0; recv_stall_pct = 0;
    test_backpressure();
    drain();
    if (err_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb_top: errors");
    $finish;
  end

endmodule
